// ===== sv/websocket_frame_receiver_defines.svh =====
// Assertion macros for the WebSocket frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define WSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define WSFR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WSFR_ASSERT(lbl, prop, msg)
`define WSFR_NEVER(lbl, expr, msg)
`endif

`endif

// ===== sv/wsfr_pkg.sv =====
// Shared constants and types for the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

  // Width of the payload length counter; longer lengths saturate.
  localparam int LEN_BITS = 64;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_byte;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
    logic       pong_request;
    logic       link_closed;
  } ws_result_t;

endpackage

`default_nettype wire

// ===== sv/wsfr_in_reg.sv =====
// Input register stage: holds one received byte until the parser takes it.
`default_nettype none

module wsfr_in_reg
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wsfr_parser.sv =====
// Frame header parser, unmasking and result generation, one byte per cycle while take is high.
`default_nettype none
`include "websocket_frame_receiver_defines.svh"

module wsfr_parser
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] s1_byte,
  output logic            res_valid,
  output ws_result_t      res
);

  logic [2:0]          phase, phase_next;
  logic                final_flag, final_flag_next;
  logic [3:0]          frame_opcode, frame_opcode_next;
  logic [3:0]          fragment_opcode, fragment_opcode_next;
  logic                masked_flag, masked_flag_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic                len_ovf, len_ovf_next;
  logic [2:0]          hdr_cnt, hdr_cnt_next;
  logic [31:0]         mask_word, mask_word_next;
  logic [1:0]          mask_index, mask_index_next;
  logic                closed, closed_next;

  logic [3:0]          msg_op;
  logic [LEN_BITS-1:0] len_shift;
  logic [LEN_BITS-1:0] len_final;
  logic                ext_last;
  logic                is_end;
  logic                fin_end;
  logic [7:0]          key;
  logic                end_taken;
  logic                close_taken;

  assign msg_op    = (frame_opcode != OP_CONT) ? frame_opcode : fragment_opcode;
  assign len_shift = {bytes_left[LEN_BITS-9:0], s1_byte};
  assign ext_last  = (hdr_cnt == ((phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST));

  assign end_taken   = take && res_valid && res.frame_end;
  assign close_taken = take && res_valid && res.link_closed;

  always_comb begin
    case (mask_index)
      2'd0:    key = mask_word[31:24];
      2'd1:    key = mask_word[23:16];
      2'd2:    key = mask_word[15:8];
      default: key = mask_word[7:0];
    endcase
    if (!masked_flag) begin
      key = 8'h00;
    end
  end

  always_comb begin
    phase_next           = phase;
    final_flag_next      = final_flag;
    frame_opcode_next    = frame_opcode;
    fragment_opcode_next = fragment_opcode;
    masked_flag_next     = masked_flag;
    bytes_left_next      = bytes_left;
    len_ovf_next         = len_ovf;
    hdr_cnt_next         = hdr_cnt;
    mask_word_next       = mask_word;
    mask_index_next      = mask_index;
    len_final            = len_shift;
    is_end               = 1'b0;
    res_valid            = 1'b0;
    res.has_byte         = 1'b0;
    res.payload_byte     = 8'h00;

    if (!closed) begin
      case (phase)
        PH_HDR1: begin
          masked_flag_next = s1_byte[7];
          hdr_cnt_next     = 3'd0;
          len_ovf_next     = 1'b0;
          bytes_left_next  = '0;
          if (s1_byte[6:0] == LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (s1_byte[6:0] == LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            bytes_left_next = LEN_BITS'(s1_byte[6:0]);
            mask_index_next = 2'd0;
            if (s1_byte[7]) begin
              phase_next     = PH_MASK;
              mask_word_next = 32'h0;
            end else if (s1_byte[6:0] == 7'd0) begin
              res_valid = 1'b1;
              is_end    = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          // bits pushed out of the counter mean the length exceeds it
          len_ovf_next = len_ovf || (|bytes_left[LEN_BITS-1 -: 8]);
          len_final    = len_ovf_next ? '1 : len_shift;
          bytes_left_next = len_final;
          if (ext_last) begin
            mask_index_next = 2'd0;
            if (masked_flag) begin
              phase_next     = PH_MASK;
              hdr_cnt_next   = 3'd0;
              mask_word_next = 32'h0;
            end else if (len_final == '0) begin
              res_valid = 1'b1;
              is_end    = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_MASK: begin
          mask_word_next = {mask_word[23:0], s1_byte};
          if (hdr_cnt == MASK_LAST) begin
            mask_index_next = 2'd0;
            if (bytes_left == '0) begin
              res_valid = 1'b1;
              is_end    = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_DATA: begin
          mask_index_next  = mask_index + 2'd1;
          bytes_left_next  = bytes_left - LEN_BITS'(1);
          res_valid        = 1'b1;
          res.has_byte     = 1'b1;
          res.payload_byte = s1_byte ^ key;
          is_end           = (bytes_left == LEN_BITS'(1));
        end
        default: begin
          final_flag_next   = s1_byte[7];
          frame_opcode_next = s1_byte[3:0];
          if (!s1_byte[7] && s1_byte[3:0] != OP_CONT) begin
            fragment_opcode_next = s1_byte[3:0];
          end
          phase_next = PH_HDR1;
        end
      endcase
    end

    fin_end            = is_end && final_flag;
    res.message_opcode = msg_op;
    res.frame_end      = is_end;
    res.message_end    = fin_end;
    res.pong_request   = fin_end && (msg_op == OP_PING);
    res.link_closed    = fin_end && (msg_op == OP_CLOSE);
    closed_next        = closed || res.link_closed;
    if (is_end) begin
      phase_next = PH_HDR0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      final_flag      <= 1'b0;
      frame_opcode    <= OP_CONT;
      fragment_opcode <= OP_CONT;
      masked_flag     <= 1'b0;
      bytes_left      <= '0;
      len_ovf         <= 1'b0;
      hdr_cnt         <= 3'd0;
      mask_word       <= 32'h0;
      mask_index      <= 2'd0;
      closed          <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      final_flag      <= final_flag_next;
      frame_opcode    <= frame_opcode_next;
      fragment_opcode <= fragment_opcode_next;
      masked_flag     <= masked_flag_next;
      bytes_left      <= bytes_left_next;
      len_ovf         <= len_ovf_next;
      hdr_cnt         <= hdr_cnt_next;
      mask_word       <= mask_word_next;
      mask_index      <= mask_index_next;
      closed          <= closed_next;
    end
  end

  `WSFR_NEVER(a_quiet_after_close, closed && res_valid, "result after close")
  `WSFR_ASSERT(a_end_to_hdr0, end_taken |=> phase == PH_HDR0, "no header phase after frame end")
  `WSFR_ASSERT(a_close_cause, $rose(closed) |-> $past(close_taken), "close without result")
  `WSFR_NEVER(a_byte_in_data, res_valid && res.has_byte && phase != PH_DATA, "byte outside data")

endmodule

`default_nettype wire

// ===== sv/wsfr_out_reg.sv =====
// Result register: holds one result item until the consumer takes it.
`default_nettype none

module wsfr_out_reg
  import wsfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire ws_result_t  res,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_free,
  output ws_result_t       out_res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver.
// Receives one link byte per item and returns at most one result per byte:
// an unmasked payload byte tagged with its message opcode, or an end marker
// for a zero-length frame, with frame end, message end, pong request and
// link closed flags. A byte is accepted every cycle when the consumer keeps
// up; a byte goes through the input register, then the result register.
// Only the last header byte of a zero-length frame gives a result. After a
// close message completes every byte is accepted and dropped until reset.
// in_ready follows out_ready combinationally.
`default_nettype none

module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            has_byte,
  output logic [7:0]      payload_byte,
  output logic [3:0]      message_opcode,
  output logic            frame_end,
  output logic            message_end,
  output logic            pong_request,
  output logic            link_closed
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       take;
  logic       out_free;
  logic       res_valid;
  ws_result_t res;
  ws_result_t out_res;

  assign take = s1_valid && out_free;

  wsfr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  wsfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .s1_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .out_res   (out_res)
  );

  assign has_byte       = out_res.has_byte;
  assign payload_byte   = out_res.payload_byte;
  assign message_opcode = out_res.message_opcode;
  assign frame_end      = out_res.frame_end;
  assign message_end    = out_res.message_end;
  assign pong_request   = out_res.pong_request;
  assign link_closed    = out_res.link_closed;

endmodule

`default_nettype wire
